// ===== design/rtq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_pkg
// shared widths, branch codes and pipeline bundles of the rotation matrix
// to quaternion unit
// ----------------------------------------------------------------------------
package rtq_pkg;

   localparam int FRAC_BITS = 16;               // q2.16 on the matrix and quaternion ports
   localparam int IO_W      = 18;               // port width of matrix and quaternion
   localparam int V_W       = 21;               // unscaled vector element, signed
   localparam int MAG_W     = 19;               // magnitude of a vector element
   localparam int SQ_W      = 2 * MAG_W;        // one square
   localparam int NSQ_W     = SQ_W + 2;         // sum of four squares
   localparam int ROOT_W    = NSQ_W / 2;        // integer square root
   localparam int REM_W     = ROOT_W + 2;       // root remainder
   localparam int Q_W       = FRAC_BITS + 1;    // quotient, at most one
   localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
   localparam int LANES     = 4;

   // front end, root, division, output register
   localparam int LATENCY   = 3 + ROOT_W + 1 + Q_W + 1;

   localparam logic [Q_W-1:0]  Q_ONE  = Q_W'(1) << FRAC_BITS;
   localparam logic [IO_W-1:0] IO_ONE = IO_W'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } rtq_branch_type;

   typedef struct packed {
      logic                            valid;
      logic                            rad_pos;
      rtq_branch_type                  branch;
      logic [LANES-1:0]                neg;
      logic [LANES-1:0][MAG_W-1:0]     mag;
   } rtq_side_type;

   typedef struct packed {
      logic                            valid;
      logic                            degen;
      rtq_branch_type                  branch;
      logic [LANES-1:0]                neg;
      logic [LANES-1:0][Q_W-1:0]       quot;
   } rtq_norm_type;

endpackage
`default_nettype wire

// ===== design/rtq_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_front
// branch choice, unscaled vector, squares and sum of squares (three stages)
// ----------------------------------------------------------------------------
module rtq_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic signed [rtq_pkg::IO_W-1:0] r00,
   input  wire logic signed [rtq_pkg::IO_W-1:0] r01,
   input  wire logic signed [rtq_pkg::IO_W-1:0] r02,
   input  wire logic signed [rtq_pkg::IO_W-1:0] r10,
   input  wire logic signed [rtq_pkg::IO_W-1:0] r11,
   input  wire logic signed [rtq_pkg::IO_W-1:0] r12,
   input  wire logic signed [rtq_pkg::IO_W-1:0] r20,
   input  wire logic signed [rtq_pkg::IO_W-1:0] r21,
   input  wire logic signed [rtq_pkg::IO_W-1:0] r22,
   output rtq_pkg::rtq_side_type              side_out,
   output logic [rtq_pkg::NSQ_W-1:0]          nsq_out
);
   import rtq_pkg::*;

   logic signed [V_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [V_W-1:0] tr, rad;
   logic signed [V_W-1:0] v [LANES];
   logic [V_W-1:0]        absv;
   rtq_side_type          side1_in, side1_ff, side2_ff, side3_ff;
   logic [SQ_W-1:0]       sq_in [LANES];
   logic [SQ_W-1:0]       sq_ff [LANES];
   logic [NSQ_W-1:0]      nsq_in, nsq_ff;

   always_comb begin
      e00 = V_W'(r00);
      e01 = V_W'(r01);
      e02 = V_W'(r02);
      e10 = V_W'(r10);
      e11 = V_W'(r11);
      e12 = V_W'(r12);
      e20 = V_W'(r20);
      e21 = V_W'(r21);
      e22 = V_W'(r22);
      tr  = e00 + e11 + e22;
      side1_in = '0;
      side1_in.valid = in_valid;
      priority if (tr > 0) begin
         side1_in.branch = BR_TRACE;
         rad  = tr + V_W'(Q_ONE);
         v[0] = rad;
         v[1] = e21 - e12;
         v[2] = e02 - e20;
         v[3] = e10 - e01;
      end else if (e00 > e11 && e00 > e22) begin
         side1_in.branch = BR_X;
         rad  = V_W'(Q_ONE) + e00 - e11 - e22;
         v[0] = e21 - e12;
         v[1] = rad;
         v[2] = e01 + e10;
         v[3] = e02 + e20;
      end else if (e11 > e22) begin
         side1_in.branch = BR_Y;
         rad  = V_W'(Q_ONE) + e11 - e00 - e22;
         v[0] = e02 - e20;
         v[1] = e01 + e10;
         v[2] = rad;
         v[3] = e12 + e21;
      end else begin
         side1_in.branch = BR_Z;
         rad  = V_W'(Q_ONE) + e22 - e00 - e11;
         v[0] = e10 - e01;
         v[1] = e02 + e20;
         v[2] = e12 + e21;
         v[3] = rad;
      end
      side1_in.rad_pos = (rad > 0);
      absv = '0;
      for (int i = 0; i < LANES; i++) begin
         side1_in.neg[i] = v[i][V_W-1];
         absv = v[i][V_W-1] ? V_W'(-v[i]) : V_W'(v[i]);
         side1_in.mag[i] = absv[MAG_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         sq_in[i] = side1_ff.mag[i] * side1_ff.mag[i];
      end
      nsq_in = NSQ_W'(sq_ff[0]) + NSQ_W'(sq_ff[1]) + NSQ_W'(sq_ff[2]) + NSQ_W'(sq_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.valid <= 1'b0;
         side2_ff.valid <= 1'b0;
         side3_ff.valid <= 1'b0;
      end else begin
         side1_ff <= side1_in;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
      end
      sq_ff  <= sq_in;
      nsq_ff <= nsq_in;
   end

   assign side_out = side3_ff;
   assign nsq_out  = nsq_ff;

endmodule
`default_nettype wire

// ===== design/rtq_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module rtq_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  rtq_pkg::rtq_side_type           side_in,
   input  wire logic [rtq_pkg::NSQ_W-1:0]  nsq_in,
   output rtq_pkg::rtq_side_type           side_out,
   output logic [rtq_pkg::ROOT_W-1:0]      root_out
);
   import rtq_pkg::*;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [NSQ_W-1:0]  x_ff    [ROOT_W];
   rtq_side_type      side_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0]  rem_src, cur, trial, rem_in;
      logic [ROOT_W-1:0] root_src, root_in;
      logic [NSQ_W-1:0]  x_src;
      rtq_side_type      side_src;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign x_src    = nsq_in;
         assign side_src = side_in;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign x_src    = x_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         cur     = {rem_src[REM_W-3:0], x_src[2*(ROOT_W-1-k)+1 -: 2]};
         trial   = {root_src, 2'b01};
         ge      = (cur >= trial);
         rem_in  = ge ? (cur - trial) : cur;
         root_in = {root_src[ROOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k].valid <= 1'b0;
         end else begin
            side_ff[k] <= side_src;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         x_ff[k]    <= x_src;
      end
   end

   assign side_out = side_ff[ROOT_W-1];
   assign root_out = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

// ===== design/rtq_norm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_norm
// rounded division of the four magnitudes by the norm, one quotient bit
// per stage in four lanes
// ----------------------------------------------------------------------------
module rtq_norm (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  rtq_pkg::rtq_side_type            side_in,
   input  wire logic [rtq_pkg::ROOT_W-1:0]  root_in,
   output rtq_pkg::rtq_norm_type            norm_out
);
   import rtq_pkg::*;

   typedef struct packed {
      logic                         valid;
      logic                         degen;
      rtq_branch_type               branch;
      logic [LANES-1:0]             neg;
      logic [ROOT_W-1:0]            den;
      logic [LANES-1:0][ROOT_W-1:0] rem;
      logic [LANES-1:0][Q_W-1:0]    low;
   } stage_type;

   stage_type        st0_in;
   stage_type        st_ff [Q_W+1];
   logic [NUM_W-1:0] num;

   // numerator with half the divisor added for rounding, split so the
   // upper part is already below the divisor
   always_comb begin
      st0_in        = '0;
      st0_in.valid  = side_in.valid;
      st0_in.degen  = !side_in.rad_pos || (root_in == '0);
      st0_in.branch = side_in.branch;
      st0_in.neg    = side_in.neg;
      st0_in.den    = root_in;
      num           = '0;
      for (int i = 0; i < LANES; i++) begin
         num = {1'b0, side_in.mag[i], {FRAC_BITS{1'b0}}} + NUM_W'(root_in >> 1);
         st0_in.rem[i] = ROOT_W'(num[NUM_W-1:Q_W]);
         st0_in.low[i] = num[Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff[0].valid <= 1'b0;
      end else begin
         st_ff[0] <= st0_in;
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      stage_type       st_in;
      logic [ROOT_W:0] rem_sh, rem_dif;
      logic            ge;

      always_comb begin
         st_in   = st_ff[k];
         rem_sh  = '0;
         rem_dif = '0;
         ge      = 1'b0;
         for (int i = 0; i < LANES; i++) begin
            rem_sh  = {st_ff[k].rem[i], st_ff[k].low[i][Q_W-1]};
            rem_dif = rem_sh - {1'b0, st_ff[k].den};
            ge      = (rem_sh >= {1'b0, st_ff[k].den});
            st_in.rem[i] = ge ? rem_dif[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
            st_in.low[i] = {st_ff[k].low[i][Q_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k+1].valid <= 1'b0;
         end else begin
            st_ff[k+1] <= st_in;
         end
      end
   end

   always_comb begin
      norm_out.valid  = st_ff[Q_W].valid;
      norm_out.degen  = st_ff[Q_W].degen;
      norm_out.branch = st_ff[Q_W].branch;
      norm_out.neg    = st_ff[Q_W].neg;
      norm_out.quot   = st_ff[Q_W].low;
   end

endmodule
`default_nettype wire

// ===== design/rotation_to_quaternion_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_to_quaternion_unit
// rotation matrix (q2.16) to unit quaternion (q2.16), shepperd branch choice
// ----------------------------------------------------------------------------
// an accepted start passes 3 front-end stages, 20 root stages, 18 division
//   stages and the output register on its way to the rsp_valid strobe
// throughput: one transaction per cycle; busy is low except during reset
// the result strobe cannot be held off, results leave in accept order
// reset (synchronous, active high) empties the pipeline: no strobe follows
// ----------------------------------------------------------------------------
module rotation_to_quaternion_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r00,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r01,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r02,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r10,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r11,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r12,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r20,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r21,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r22,
   output logic                               rsp_valid,
   output logic signed [rtq_pkg::IO_W-1:0]    rsp_quat_w,
   output logic signed [rtq_pkg::IO_W-1:0]    rsp_quat_x,
   output logic signed [rtq_pkg::IO_W-1:0]    rsp_quat_y,
   output logic signed [rtq_pkg::IO_W-1:0]    rsp_quat_z,
   output logic [1:0]                         rsp_branch_used,
   output logic                               rsp_degenerate
);
   import rtq_pkg::*;

   logic              req_accept;
   rtq_side_type      front_side, root_side;
   logic [NSQ_W-1:0]  front_nsq;
   logic [ROOT_W-1:0] root_val;
   rtq_norm_type      norm;

   logic                  valid_in, valid_ff;
   logic [IO_W-1:0]       part_in [LANES];
   logic [IO_W-1:0]       part_ff [LANES];
   logic [Q_W-1:0]        qclamp;
   logic [1:0]            branch_in, branch_ff;
   logic                  degen_in, degen_ff;

   // the pipeline never stalls, so a transaction is refused only in reset
   assign busy       = reset;
   assign req_accept = start && !busy;

   // branch choice, vector and sum of squares
   rtq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_accept),
      .r00      (req_r00),
      .r01      (req_r01),
      .r02      (req_r02),
      .r10      (req_r10),
      .r11      (req_r11),
      .r12      (req_r12),
      .r20      (req_r20),
      .r21      (req_r21),
      .r22      (req_r22),
      .side_out (front_side),
      .nsq_out  (front_nsq)
   );

   // norm = floor of the square root of the sum of squares
   rtq_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .side_in  (front_side),
      .nsq_in   (front_nsq),
      .side_out (root_side),
      .root_out (root_val)
   );

   // each magnitude scaled by one over the norm, rounded half away from zero
   rtq_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .side_in  (root_side),
      .root_in  (root_val),
      .norm_out (norm)
   );

   // sign, clamp to plus or minus one, identity for a degenerate matrix
   always_comb begin
      valid_in  = norm.valid;
      degen_in  = norm.degen;
      branch_in = norm.branch;
      qclamp    = '0;
      for (int i = 0; i < LANES; i++) begin
         qclamp = (norm.quot[i] > Q_ONE) ? Q_ONE : norm.quot[i];
         if (norm.degen) begin
            part_in[i] = (i == 0) ? IO_ONE : '0;
         end else if (norm.neg[i]) begin
            part_in[i] = IO_W'(-IO_W'(qclamp));
         end else begin
            part_in[i] = IO_W'(qclamp);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      part_ff   <= part_in;
      branch_ff <= branch_in;
      degen_ff  <= degen_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_quat_w      = part_ff[0];
   assign rsp_quat_x      = part_ff[1];
   assign rsp_quat_y      = part_ff[2];
   assign rsp_quat_z      = part_ff[3];
   assign rsp_branch_used = branch_ff;
   assign rsp_degenerate  = degen_ff;

`ifndef SYNTHESIS
   // every accepted transaction is answered a fixed time later
   a_latency : assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##LATENCY rsp_valid)
      else $error("accepted transaction not answered in time");

   // no strobe without a transaction accepted a fixed time before
   a_no_stray : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, LATENCY))
      else $error("result strobe does not match accepted transaction");

   // identity on degenerate input
   a_identity : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_quat_w == IO_ONE && rsp_quat_x == '0 && rsp_quat_y == '0 && rsp_quat_z == '0)
      else $error("degenerate result is not the identity");

   // parts stay within plus or minus one
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_quat_w <= $signed(IO_ONE) && rsp_quat_w >= -$signed(IO_ONE) &&
         rsp_quat_x <= $signed(IO_ONE) && rsp_quat_x >= -$signed(IO_ONE) &&
         rsp_quat_y <= $signed(IO_ONE) && rsp_quat_y >= -$signed(IO_ONE) &&
         rsp_quat_z <= $signed(IO_ONE) && rsp_quat_z >= -$signed(IO_ONE))
      else $error("quaternion part out of range");
`endif

endmodule
`default_nettype wire

// ===== bench/rtq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtq_checker
// watches both channels of the rotation to quaternion unit, predicts each
// quaternion from the accepted matrix and compares in arrival order
// ----------------------------------------------------------------------------
module rtq_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r00,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r01,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r02,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r10,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r11,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r12,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r20,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r21,
   input  wire logic signed [rtq_pkg::IO_W-1:0] req_r22,
   input  wire logic                            rsp_valid,
   input  wire logic signed [rtq_pkg::IO_W-1:0] rsp_quat_w,
   input  wire logic signed [rtq_pkg::IO_W-1:0] rsp_quat_x,
   input  wire logic signed [rtq_pkg::IO_W-1:0] rsp_quat_y,
   input  wire logic signed [rtq_pkg::IO_W-1:0] rsp_quat_z,
   input  wire logic [1:0]                      rsp_branch_used,
   input  wire logic                            rsp_degenerate,
   output int                                   mismatches,
   output int                                   outstanding
);
   import rtq_pkg::*;

   typedef struct packed {
      logic signed [IO_W-1:0] w;
      logic signed [IO_W-1:0] x;
      logic signed [IO_W-1:0] y;
      logic signed [IO_W-1:0] z;
      rtq_branch_type         branch;
      logic                   degen;
   } quat_type;

   quat_type expected_quats[$];

   function automatic longint unsigned int_sqrt(longint unsigned a);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > a) bitv >>= 2;
      while (bitv != 0) begin
         if (a >= res + bitv) begin
            a   = a - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // clamp to [-one, one]; that range always fits the port
   function automatic logic signed [IO_W-1:0] clamp_part(longint p);
      longint one;
      one = longint'(1) << FRAC_BITS;
      if (p > one) p = one;
      if (p < -one) p = -one;
      return IO_W'(p);
   endfunction

   // v / n in q2.16, rounded half away from zero
   function automatic longint scale_part(longint v, longint unsigned n);
      longint unsigned mag;
      longint unsigned q;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      q   = ((mag << FRAC_BITS) + (n >> 1)) / n;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic quat_type matrix_to_quat(longint m00, longint m01, longint m02,
                                               longint m10, longint m11, longint m12,
                                               longint m20, longint m21, longint m22);
      quat_type        q;
      longint          one;
      longint          tr;
      longint          rad;
      longint          v[4];
      longint unsigned nsq;
      longint unsigned n;
      longint unsigned mag;
      one = longint'(1) << FRAC_BITS;
      tr  = m00 + m11 + m22;
      if (tr > 0) begin
         q.branch = BR_TRACE;
         rad = tr + one;
         v[0] = rad; v[1] = m21 - m12; v[2] = m02 - m20; v[3] = m10 - m01;
      end else if (m00 > m11 && m00 > m22) begin
         q.branch = BR_X;
         rad = one + m00 - m11 - m22;
         v[0] = m21 - m12; v[1] = rad; v[2] = m01 + m10; v[3] = m02 + m20;
      end else if (m11 > m22) begin
         q.branch = BR_Y;
         rad = one + m11 - m00 - m22;
         v[0] = m02 - m20; v[1] = m01 + m10; v[2] = rad; v[3] = m12 + m21;
      end else begin
         q.branch = BR_Z;
         rad = one + m22 - m00 - m11;
         v[0] = m10 - m01; v[1] = m02 + m20; v[2] = m12 + m21; v[3] = rad;
      end
      n   = 0;
      nsq = 0;
      if (rad > 0) begin
         for (int i = 0; i < 4; i++) begin
            mag = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            nsq += mag * mag;
         end
         n = int_sqrt(nsq);
      end
      if (rad <= 0 || n == 0) begin
         // not a rotation: identity with the flag raised
         q.w = clamp_part(one);
         q.x = '0;
         q.y = '0;
         q.z = '0;
         q.degen = 1'b1;
      end else begin
         q.w = clamp_part(scale_part(v[0], n));
         q.x = clamp_part(scale_part(v[1], n));
         q.y = clamp_part(scale_part(v[2], n));
         q.z = clamp_part(scale_part(v[3], n));
         q.degen = 1'b0;
      end
      return q;
   endfunction

   always @(posedge clock) begin
      quat_type e;
      quat_type a;
      if (!reset) begin
         if (start && !busy)
            expected_quats.insert(expected_quats.size(),
                                  matrix_to_quat(req_r00, req_r01, req_r02,
                                                 req_r10, req_r11, req_r12,
                                                 req_r20, req_r21, req_r22));
         if (rsp_valid) begin
            a.w = rsp_quat_w;
            a.x = rsp_quat_x;
            a.y = rsp_quat_y;
            a.z = rsp_quat_z;
            a.branch = rtq_branch_type'(rsp_branch_used);
            a.degen = rsp_degenerate;
            if (expected_quats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected transaction w=%0d x=%0d y=%0d z=%0d",
                           $realtime, a.w, a.x, a.y, a.z);
            end else begin
               e = expected_quats.pop_front();
               if (a !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: mismatch exp w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0b,",
                               " got w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0b"},
                              $realtime, e.w, e.x, e.y, e.z, e.branch, e.degen,
                              a.w, a.x, a.y, a.z, a.branch, a.degen);
               end
            end
         end
      end
      outstanding <= expected_quats.size();
   end

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives matrices into the rotation to quaternion unit: a directed set of
// extremes and axis rotations, then random rotations and raw noise, with
// random idle cycles; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module testbench;
   import rtq_pkg::*;

   localparam int  NUM_RANDOM  = 1730;
   localparam int  CYCLE_LIMIT = 200000;
   localparam int  ONE         = 1 << FRAC_BITS;
   localparam int  MAXV        = 131071;
   localparam int  MINV        = -131072;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [IO_W-1:0] m[9];
   logic rsp_valid;
   logic signed [IO_W-1:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   logic [1:0] rsp_branch_used;
   logic rsp_degenerate;
   int   mismatches;
   int   outstanding;
   int   cycles;
   bit   quiet_stretch;

   rotation_to_quaternion_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_r00(m[0]), .req_r01(m[1]), .req_r02(m[2]),
      .req_r10(m[3]), .req_r11(m[4]), .req_r12(m[5]),
      .req_r20(m[6]), .req_r21(m[7]), .req_r22(m[8]),
      .rsp_valid(rsp_valid),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_branch_used(rsp_branch_used), .rsp_degenerate(rsp_degenerate)
   );

   rtq_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_r00(m[0]), .req_r01(m[1]), .req_r02(m[2]),
      .req_r10(m[3]), .req_r11(m[4]), .req_r12(m[5]),
      .req_r20(m[6]), .req_r21(m[7]), .req_r22(m[8]),
      .rsp_valid(rsp_valid),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_branch_used(rsp_branch_used), .rsp_degenerate(rsp_degenerate),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung pipeline ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[rotation_to_quaternion_unit] ERROR");
         $finish;
      end
   end

   // one matrix: present it, then hold it until the unit takes it
   task automatic send_matrix(input int e[9]);
      int gap;
      gap = 0;
      if (!quiet_stretch && $urandom_range(99) < 16)
         gap = 1;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      for (int i = 0; i < 9; i++) m[i] <= IO_W'(e[i]);
      do @(posedge clock); while (busy);
   endtask

   // entries of a rotation built from a random quaternion, with a little jitter
   task automatic random_rotation(output int e[9]);
      real qw, qx, qy, qz, nrm;
      real r[9];
      qw = $urandom_range(2000) - 1000.0;
      qx = $urandom_range(2000) - 1000.0;
      qy = $urandom_range(2000) - 1000.0;
      qz = $urandom_range(2000) - 1000.0;
      nrm = $sqrt(qw*qw + qx*qx + qy*qy + qz*qz);
      if (nrm < 1.0) begin
         qw = 1.0; nrm = 1.0;
      end
      qw /= nrm; qx /= nrm; qy /= nrm; qz /= nrm;
      r[0] = 1 - 2*(qy*qy + qz*qz); r[1] = 2*(qx*qy - qz*qw); r[2] = 2*(qx*qz + qy*qw);
      r[3] = 2*(qx*qy + qz*qw); r[4] = 1 - 2*(qx*qx + qz*qz); r[5] = 2*(qy*qz - qx*qw);
      r[6] = 2*(qx*qz - qy*qw); r[7] = 2*(qy*qz + qx*qw); r[8] = 1 - 2*(qx*qx + qy*qy);
      for (int i = 0; i < 9; i++)
         e[i] = $rtoi(r[i] * ONE) + $urandom_range(8) - 4;
   endtask

   initial begin
      int e[9];
      int kind;
      cycles        = 0;
      quiet_stretch = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      for (int i = 0; i < 9; i++) m[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, half turns about each axis, extremes, ties
      e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};               send_matrix(e);
      e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};             send_matrix(e);
      e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};             send_matrix(e);
      e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};             send_matrix(e);
      e = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE};              send_matrix(e);
      e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                     send_matrix(e);
      e = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}; send_matrix(e);
      e = '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}; send_matrix(e);
      e = '{MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV, MINV}; send_matrix(e);
      e = '{MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV, MINV}; send_matrix(e);
      e = '{MINV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MAXV}; send_matrix(e);
      e = '{-1, 5, -7, 9, -1, 3, -4, 2, -1};                send_matrix(e);
      e = '{-5, 1, 1, 1, -3, 1, 1, 1, -3};                  send_matrix(e);
      e = '{0, 1, 0, 0, 0, 0, 0, 0, 0};                     send_matrix(e);
      e = '{1, 0, 0, 0, 0, 0, 0, 0, -1};                    send_matrix(e);
      e = '{-ONE, MAXV, MINV, MINV, -ONE, MAXV, MAXV, MINV, 0}; send_matrix(e);

      // random: mostly rotations, some small matrices, the rest full-range noise
      for (int k = 0; k < NUM_RANDOM; k++) begin
         quiet_stretch = (k >= 700 && k < 1000);
         kind = $urandom_range(99);
         if (kind < 65) begin
            random_rotation(e);
         end else if (kind < 80) begin
            // small entries with one large diagonal entry
            for (int i = 0; i < 9; i++) e[i] = $urandom_range(200) - 100;
            e[$urandom_range(2) * 4] = $urandom_range(ONE);
         end else begin
            for (int i = 0; i < 9; i++) e[i] = $urandom_range(MAXV - MINV) + MINV;
         end
         send_matrix(e);
      end
      start <= 1'b0;

      // drain the pipeline, then wait on for stray strobes
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0)
         $display("[rotation_to_quaternion_unit] OK");
      else
         $display("[rotation_to_quaternion_unit] ERROR");
      $finish;
   end

endmodule
